/* sv/mfr_pkg.sv */
// ----------------------------------------------------------------------------
// MS/TP frame receiver package
// Shared types, codes and constants of the frame receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mfr_pkg;

  localparam int unsigned COUNT_WIDTH = 32;

  localparam logic [7:0]  PRE0          = 8'h55;
  localparam logic [7:0]  PRE1          = 8'hFF;
  localparam int unsigned HDR_LEN       = 8;
  localparam logic [2:0]  HDR_LAST      = 3'(HDR_LEN - 1);
  localparam logic [15:0] MAX_LEN_RESET = 16'd501;

  localparam logic [7:0] TYPE_TOKEN = 8'd0;
  localparam logic [7:0] TYPE_PFM   = 8'd1;
  localparam logic [7:0] TYPE_REPLY = 8'd2;
  localparam logic [7:0] TYPE_DATA0 = 8'd5;
  localparam logic [7:0] TYPE_DATA1 = 8'd6;

  localparam int unsigned NUM_CNT   = 7;
  localparam logic [2:0]  C_FRAME   = 3'd0;
  localparam logic [2:0]  C_TOKEN   = 3'd1;
  localparam logic [2:0]  C_PFM     = 3'd2;
  localparam logic [2:0]  C_REPLY   = 3'd3;
  localparam logic [2:0]  C_DATA    = 3'd4;
  localparam logic [2:0]  C_INVALID = 3'd5;
  localparam logic [2:0]  C_NOISE   = 3'd6;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_FRAME   = 2'd1,
    EV_INVALID = 2'd2
  } event_e;

  typedef struct packed {
    logic [7:0] rx_byte;
  } rx_item_t;

  typedef struct packed {
    logic [1:0]  event_res;
    logic [7:0]  frame_type;
    logic [15:0] data_length;
    logic [31:0] frame_count;
    logic [31:0] token_count;
    logic [31:0] poll_master_count;
    logic [31:0] reply_poll_count;
    logic [31:0] data_frame_count;
    logic [31:0] invalid_count;
    logic [31:0] noise_count;
  } result_t;

  typedef struct packed {
    logic capture;
    logic step;
    logic scan;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic reject;
    logic scan_done;
  } status_t;

endpackage

`default_nettype wire

/* sv/mfr_stream_if.sv */
// ----------------------------------------------------------------------------
// MS/TP frame receiver stream interface
// Valid/ready channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface mfr_stream_if #(
  parameter type payload_t = logic [7:0]
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* sv/mfr_datapath.sv */
// ----------------------------------------------------------------------------
// MS/TP frame receiver datapath
// Header window, payload skip counter, event counters and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mfr_datapath #(
  parameter int unsigned COUNT_WIDTH = mfr_pkg::COUNT_WIDTH
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [15:0]      cfg_wdata_i,
  input  wire logic [7:0]       rx_byte_i,
  input  wire mfr_pkg::cmd_t    cmd_i,
  output mfr_pkg::status_t      status_o,
  output mfr_pkg::result_t      result_o
);

  logic [15:0] max_len_q;
  logic [7:0]  byte_q, byte_d;
  logic [7:0]  win_q [8];
  logic [7:0]  win_d [8];
  logic [2:0]  fill_q, fill_d;
  logic [16:0] rem_q, rem_d;
  logic [7:0]  ptype_q, ptype_d;
  logic [15:0] plen_q, plen_d;
  logic [COUNT_WIDTH-1:0] cnt_q [mfr_pkg::NUM_CNT];
  logic [COUNT_WIDTH-1:0] cnt_d [mfr_pkg::NUM_CNT];
  mfr_pkg::event_e ev_q, ev_d;
  logic [7:0]  etype_q, etype_d;
  logic [15:0] elen_q, elen_d;
  mfr_pkg::result_t res_q, res_d;

  logic        pre_front;
  logic [15:0] hdr_len;
  logic        frame_inc;
  logic [7:0]  frame_t;

  assign pre_front = (win_q[0] == mfr_pkg::PRE0) && (win_q[1] == mfr_pkg::PRE1);
  assign hdr_len   = {win_q[5], win_q[6]};

  assign status_o.reject    = (rem_q == 17'd0) && (fill_q == mfr_pkg::HDR_LAST) &&
                              (hdr_len > max_len_q);
  assign status_o.scan_done = (fill_q < 3'd2) || pre_front;

  always_comb begin
    byte_d    = byte_q;
    win_d     = win_q;
    fill_d    = fill_q;
    rem_d     = rem_q;
    ptype_d   = ptype_q;
    plen_d    = plen_q;
    cnt_d     = cnt_q;
    ev_d      = ev_q;
    etype_d   = etype_q;
    elen_d    = elen_q;
    res_d     = res_q;
    frame_inc = 1'b0;
    frame_t   = ptype_q;

    if (cmd_i.capture) begin
      byte_d = rx_byte_i;
    end

    if (cmd_i.step) begin
      ev_d    = mfr_pkg::EV_NONE;
      etype_d = 8'd0;
      elen_d  = 16'd0;
      if (rem_q != 17'd0) begin
        rem_d = rem_q - 17'd1;
        if (rem_q == 17'd1) begin
          frame_inc = 1'b1;
          frame_t   = ptype_q;
          ev_d      = mfr_pkg::EV_FRAME;
          etype_d   = ptype_q;
          elen_d    = plen_q;
        end
      end else if (fill_q == mfr_pkg::HDR_LAST) begin
        if (status_o.reject) begin
          cnt_d[mfr_pkg::C_INVALID] = cnt_q[mfr_pkg::C_INVALID] + COUNT_WIDTH'(1);
          ev_d    = mfr_pkg::EV_INVALID;
          etype_d = win_q[2];
          elen_d  = hdr_len;
          // drop the first header byte
          for (int i = 0; i < 6; i++) begin
            win_d[i] = win_q[i+1];
          end
          win_d[6] = byte_q;
          fill_d   = mfr_pkg::HDR_LAST;
        end else if (hdr_len == 16'd0) begin
          frame_inc = 1'b1;
          frame_t   = win_q[2];
          ev_d      = mfr_pkg::EV_FRAME;
          etype_d   = win_q[2];
          fill_d    = 3'd0;
        end else begin
          ptype_d = win_q[2];
          plen_d  = hdr_len;
          rem_d   = {1'b0, hdr_len} + 17'd2;
          fill_d  = 3'd0;
        end
      end else if (fill_q == 3'd1) begin
        if ((win_q[0] == mfr_pkg::PRE0) && (byte_q == mfr_pkg::PRE1)) begin
          win_d[1] = byte_q;
          fill_d   = 3'd2;
        end else begin
          cnt_d[mfr_pkg::C_NOISE] = cnt_q[mfr_pkg::C_NOISE] + COUNT_WIDTH'(1);
          win_d[0] = byte_q;
        end
      end else begin
        win_d[fill_q] = byte_q;
        fill_d        = fill_q + 3'd1;
      end
    end

    if (cmd_i.scan && !status_o.scan_done) begin
      for (int i = 0; i < 7; i++) begin
        win_d[i] = win_q[i+1];
      end
      fill_d = fill_q - 3'd1;
      cnt_d[mfr_pkg::C_NOISE] = cnt_q[mfr_pkg::C_NOISE] + COUNT_WIDTH'(1);
    end

    if (frame_inc) begin
      cnt_d[mfr_pkg::C_FRAME] = cnt_q[mfr_pkg::C_FRAME] + COUNT_WIDTH'(1);
      case (frame_t)
        mfr_pkg::TYPE_TOKEN: begin
          cnt_d[mfr_pkg::C_TOKEN] = cnt_q[mfr_pkg::C_TOKEN] + COUNT_WIDTH'(1);
        end
        mfr_pkg::TYPE_PFM: begin
          cnt_d[mfr_pkg::C_PFM] = cnt_q[mfr_pkg::C_PFM] + COUNT_WIDTH'(1);
        end
        mfr_pkg::TYPE_REPLY: begin
          cnt_d[mfr_pkg::C_REPLY] = cnt_q[mfr_pkg::C_REPLY] + COUNT_WIDTH'(1);
        end
        mfr_pkg::TYPE_DATA0, mfr_pkg::TYPE_DATA1: begin
          cnt_d[mfr_pkg::C_DATA] = cnt_q[mfr_pkg::C_DATA] + COUNT_WIDTH'(1);
        end
        default: begin
        end
      endcase
    end

    if (cmd_i.emit) begin
      res_d.event_res         = ev_q;
      res_d.frame_type        = etype_q;
      res_d.data_length       = elen_q;
      res_d.frame_count       = 32'(cnt_q[mfr_pkg::C_FRAME]);
      res_d.token_count       = 32'(cnt_q[mfr_pkg::C_TOKEN]);
      res_d.poll_master_count = 32'(cnt_q[mfr_pkg::C_PFM]);
      res_d.reply_poll_count  = 32'(cnt_q[mfr_pkg::C_REPLY]);
      res_d.data_frame_count  = 32'(cnt_q[mfr_pkg::C_DATA]);
      res_d.invalid_count     = 32'(cnt_q[mfr_pkg::C_INVALID]);
      res_d.noise_count       = 32'(cnt_q[mfr_pkg::C_NOISE]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= mfr_pkg::MAX_LEN_RESET;
      fill_q    <= 3'd0;
      rem_q     <= 17'd0;
      for (int i = 0; i < mfr_pkg::NUM_CNT; i++) begin
        cnt_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        max_len_q <= cfg_wdata_i;
      end
      fill_q <= fill_d;
      rem_q  <= rem_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q  <= byte_d;
    win_q   <= win_d;
    ptype_q <= ptype_d;
    plen_q  <= plen_d;
    ev_q    <= ev_d;
    etype_q <= etype_d;
    elen_q  <= elen_d;
    res_q   <= res_d;
  end

  assign result_o = res_q;

endmodule

`default_nettype wire

/* sv/mfr_ctrl.sv */
// ----------------------------------------------------------------------------
// MS/TP frame receiver controller
// Sequences capture, step, rescan and result hand-off for each byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mfr_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  input  wire mfr_pkg::status_t  status_i,
  output mfr_pkg::cmd_t          cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_STEP = 4'b0010,
    S_SCAN = 4'b0100,
    S_EMIT = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_STEP;
        end
      end
      S_STEP: begin
        cmd_o.step = 1'b1;
        state_d    = status_i.reject ? S_SCAN : S_EMIT;
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (status_i.scan_done) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.emit  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

/* sv/mstp_frame_receiver_unit.sv */
// ----------------------------------------------------------------------------
// MS/TP frame receiver unit
// Byte-serial frame receiver with preamble hunt, length check and counters.
// ----------------------------------------------------------------------------
// Usage:
//   rx_i carries one received serial byte per transfer; res_o returns exactly
//   one result per byte: the event code, the header type and length of a
//   completed or rejected frame, and the seven event counters.
//   cfg_we_i / cfg_wdata_i write the largest accepted data length; write it
//   only while no byte is in flight.
//   A byte is taken in the idle state, processed in the step state in the
//   next cycle, and its result is loaded into the output register in the
//   emit state. A header rejected for its length first passes through the
//   scan state, which drops one byte per shift step of the window register
//   until a preamble stands at the window front or fewer than two bytes remain.
//   A new byte is taken only once the previous result has been loaded.
//   A new byte is taken while the previous result still waits in the output
//   register; when the receiver stalls, the next result holds in its final
//   cycle until the output register is free.
//   Reset empties the window, clears the skip counter and all counters, and
//   sets the length limit to 501; no result is pending after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mstp_frame_receiver_unit #(
  parameter int unsigned COUNT_WIDTH = mfr_pkg::COUNT_WIDTH
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  mfr_stream_if.sink       rx_i,
  mfr_stream_if.source     res_o
);

  mfr_pkg::cmd_t    cmd;
  mfr_pkg::status_t status;
  mfr_pkg::result_t result;

  mfr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (rx_i.valid),
    .in_ready_o  (rx_i.ready),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  mfr_datapath #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .rx_byte_i   (rx_i.data.rx_byte),
    .cmd_i       (cmd),
    .status_o    (status),
    .result_o    (result)
  );

  assign res_o.data = result;

`ifndef ASSERT_OFF
  a_one_byte_in_flight : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (rx_i.valid && rx_i.ready) |=> !rx_i.ready
  ) else $error("byte transfer not followed by busy");

  a_event_code : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (res_o.data.event_res == mfr_pkg::EV_NONE ||
                     res_o.data.event_res == mfr_pkg::EV_FRAME ||
                     res_o.data.event_res == mfr_pkg::EV_INVALID)
  ) else $error("undefined event code");

  a_idle_header_zero : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.data.event_res == mfr_pkg::EV_NONE) |->
      (res_o.data.frame_type == 8'd0 && res_o.data.data_length == 16'd0)
  ) else $error("header fields set without an event");
`endif

endmodule

`default_nettype wire

/* test/testbench.sv */
// ----------------------------------------------------------------------------
// MS/TP frame receiver unit testbench
// Streams serial bytes into the receiver and checks every per-byte result
// against a scoreboard that tracks the header window, payload skip and
// counters. Covers preamble hunting, each frame type, length limit edges,
// rejection with rescan and long payloads, under several limit settings
// and random idling on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  class frame_tally_board;
    logic [15:0]       len_limit;
    logic [7:0]        hdr [mfr_pkg::HDR_LEN];
    int unsigned       hdr_fill;
    logic [16:0]       skip_left;
    logic [7:0]        held_type;
    logic [15:0]       held_len;
    logic [31:0]       tally [mfr_pkg::NUM_CNT];
    mfr_pkg::result_t  expected_tallies [$];
    int unsigned       mismatches;

    function new();
      len_limit  = mfr_pkg::MAX_LEN_RESET;
      hdr_fill   = 0;
      skip_left  = '0;
      held_type  = '0;
      held_len   = '0;
      mismatches = 0;
      foreach (hdr[i]) hdr[i] = '0;
      foreach (tally[i]) tally[i] = '0;
    endfunction

    function void shift_out(int unsigned n);
      if (n >= hdr_fill) begin
        hdr_fill = 0;
        return;
      end
      for (int unsigned i = 0; i < hdr_fill - n; i++) hdr[i] = hdr[i + n];
      hdr_fill -= n;
    endfunction

    function void hunt_preamble();
      int unsigned s;
      s = 0;
      if (hdr_fill < 2) return;
      while (s + 1 < hdr_fill &&
             !(hdr[s] == mfr_pkg::PRE0 && hdr[s + 1] == mfr_pkg::PRE1)) s++;
      if (s > 0) begin
        tally[mfr_pkg::C_NOISE] += 32'(s);
        shift_out(s);
      end
    endfunction

    function void count_frame(logic [7:0] ftype);
      tally[mfr_pkg::C_FRAME]++;
      case (ftype)
        mfr_pkg::TYPE_TOKEN: tally[mfr_pkg::C_TOKEN]++;
        mfr_pkg::TYPE_PFM: tally[mfr_pkg::C_PFM]++;
        mfr_pkg::TYPE_REPLY: tally[mfr_pkg::C_REPLY]++;
        mfr_pkg::TYPE_DATA0, mfr_pkg::TYPE_DATA1: tally[mfr_pkg::C_DATA]++;
        default: ;
      endcase
    endfunction

    function void take_byte(logic [7:0] b);
      mfr_pkg::result_t r;
      logic [15:0]      len;
      r = '0;
      if (skip_left != 0) begin
        skip_left--;
        if (skip_left == 0) begin
          count_frame(held_type);
          r.event_res   = mfr_pkg::EV_FRAME;
          r.frame_type  = held_type;
          r.data_length = held_len;
        end
      end else begin
        hdr[hdr_fill] = b;
        hdr_fill++;
        hunt_preamble();
        if (hdr_fill >= mfr_pkg::HDR_LEN) begin
          len = {hdr[5], hdr[6]};
          if (len > len_limit) begin
            tally[mfr_pkg::C_INVALID]++;
            r.event_res   = mfr_pkg::EV_INVALID;
            r.frame_type  = hdr[2];
            r.data_length = len;
            shift_out(1);
            hunt_preamble();
          end else if (len == 0) begin
            count_frame(hdr[2]);
            r.event_res  = mfr_pkg::EV_FRAME;
            r.frame_type = hdr[2];
            hdr_fill     = 0;
          end else begin
            held_type = hdr[2];
            held_len  = len;
            skip_left = {1'b0, len} + 17'd2;
            hdr_fill  = 0;
          end
        end
      end
      r.frame_count       = tally[mfr_pkg::C_FRAME];
      r.token_count       = tally[mfr_pkg::C_TOKEN];
      r.poll_master_count = tally[mfr_pkg::C_PFM];
      r.reply_poll_count  = tally[mfr_pkg::C_REPLY];
      r.data_frame_count  = tally[mfr_pkg::C_DATA];
      r.invalid_count     = tally[mfr_pkg::C_INVALID];
      r.noise_count       = tally[mfr_pkg::C_NOISE];
      expected_tallies.push_back(r);
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
    endfunction

    function void match_result(mfr_pkg::result_t got);
      mfr_pkg::result_t want;
      if (expected_tallies.size() == 0) begin
        mismatches++;
        $display("%0t: result with none expected, expected none, actual %h", $time, got);
        return;
      end
      want = expected_tallies.pop_front();
      check_field("event_res", 32'(want.event_res), 32'(got.event_res));
      check_field("frame_type", 32'(want.frame_type), 32'(got.frame_type));
      check_field("data_length", 32'(want.data_length), 32'(got.data_length));
      check_field("frame_count", want.frame_count, got.frame_count);
      check_field("token_count", want.token_count, got.token_count);
      check_field("poll_master_count", want.poll_master_count, got.poll_master_count);
      check_field("reply_poll_count", want.reply_poll_count, got.reply_poll_count);
      check_field("data_frame_count", want.data_frame_count, got.data_frame_count);
      check_field("invalid_count", want.invalid_count, got.invalid_count);
      check_field("noise_count", want.noise_count, got.noise_count);
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [15:0] cfg_wdata_i;

  mfr_stream_if #(.payload_t(mfr_pkg::rx_item_t)) rx_if ();
  mfr_stream_if #(.payload_t(mfr_pkg::result_t))  res_if ();

  frame_tally_board board;
  int unsigned      send_idle_pct = 0;
  int unsigned      recv_stall_pct = 0;
  int unsigned      bytes_sent = 0;

  mstp_frame_receiver_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .rx_i        (rx_if),
    .res_o       (res_if)
  );

  always #5 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rx_if.valid && rx_if.ready) board.take_byte(rx_if.data.rx_byte);
      if (res_if.valid && res_if.ready) board.match_result(res_if.data);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      rx_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    rx_if.valid <= 1'b1;
    rx_if.data  <= b;
    @(posedge clk_i);
    while (!rx_if.ready) @(posedge clk_i);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_header(input logic [7:0] ftype, input logic [15:0] len,
                             input logic [7:0] crc);
    send_byte(mfr_pkg::PRE0);
    send_byte(mfr_pkg::PRE1);
    send_byte(ftype);
    send_byte(8'($urandom));
    send_byte(8'($urandom));
    send_byte(len[15:8]);
    send_byte(len[7:0]);
    send_byte(crc);
  endtask

  task automatic skip_payload(input int unsigned n);
    repeat (n) send_byte(8'($urandom));
  endtask

  task automatic settle();
    rx_if.valid <= 1'b0;
    while (board.expected_tallies.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_limit(input logic [15:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    board.len_limit = v;
    @(negedge clk_i);
  endtask

  function automatic logic [7:0] pick_type();
    case ($urandom_range(9))
      0: return mfr_pkg::TYPE_TOKEN;
      1: return mfr_pkg::TYPE_PFM;
      2: return mfr_pkg::TYPE_REPLY;
      3: return mfr_pkg::TYPE_DATA0;
      4: return mfr_pkg::TYPE_DATA1;
      5: return 8'd3;
      6: return 8'd4;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_length(input logic [15:0] limit);
    if ($urandom_range(4) == 0 && limit != 16'hFFFF)
      return 16'($urandom_range(65535, limit + 1));
    return 16'($urandom_range(24));
  endfunction

  task automatic send_random_traffic(input int unsigned n_bytes);
    int unsigned stop_at;
    int unsigned roll;
    logic [15:0] len;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      roll = $urandom_range(99);
      if (roll < 10) begin
        skip_payload($urandom_range(1, 4));
      end else if (roll < 18) begin
        send_byte(mfr_pkg::PRE0);
        if ($urandom_range(1)) send_byte(mfr_pkg::PRE1);
        skip_payload($urandom_range(5));
      end else begin
        len = pick_length(board.len_limit);
        send_header(pick_type(), len, 8'($urandom));
        if (len != 0 && len <= board.len_limit) skip_payload(len + 2);
      end
    end
  endtask

  initial begin
    board = new();
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = '0;
    rx_if.valid  = 1'b0;
    rx_if.data   = '0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_byte(8'h00);
    send_byte(mfr_pkg::PRE0);
    send_header(mfr_pkg::TYPE_TOKEN, 16'd0, 8'hA5);
    send_header(mfr_pkg::TYPE_PFM, 16'd0, 8'h3C);
    send_header(mfr_pkg::TYPE_REPLY, 16'd0, 8'h00);
    send_header(mfr_pkg::TYPE_DATA0, 16'd1, 8'hFF);
    skip_payload(3);
    send_header(mfr_pkg::TYPE_DATA1, 16'd0, 8'h81);
    send_header(8'd3, 16'd0, 8'h42);
    send_header(8'hFF, 16'd0, 8'h18);
    send_header(mfr_pkg::TYPE_TOKEN, mfr_pkg::MAX_LEN_RESET + 16'd1, 8'h7E);
    // rejected header whose tail holds a fresh preamble
    send_byte(mfr_pkg::PRE0);
    send_byte(mfr_pkg::PRE1);
    send_byte(8'h07);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(mfr_pkg::PRE0);
    send_byte(mfr_pkg::PRE1);
    send_byte(mfr_pkg::TYPE_PFM);
    skip_payload(0);
    send_byte(8'h00);
    send_byte(8'h10);
    send_byte(8'h20);
    send_byte(8'h00);
    send_byte(8'h00);
    settle();

    write_limit(16'h0000);
    send_header(mfr_pkg::TYPE_DATA0, 16'd1, 8'h11);
    send_header(mfr_pkg::TYPE_TOKEN, 16'd0, 8'h22);
    settle();
    write_limit(16'd300);
    send_header(mfr_pkg::TYPE_DATA1, 16'd300, 8'h33);
    skip_payload(302);
    send_header(mfr_pkg::TYPE_DATA0, 16'd301, 8'h44);
    settle();
    write_limit(16'hFFFE);
    send_header(mfr_pkg::TYPE_REPLY, 16'hFFFF, 8'h55);
    settle();

    write_limit(mfr_pkg::MAX_LEN_RESET);
    send_random_traffic(150);
    settle();

    send_idle_pct = 57;
    write_limit(16'h0000);
    send_random_traffic(150);
    settle();

    send_idle_pct  = 0;
    recv_stall_pct = 57;
    write_limit(16'd12);
    send_random_traffic(150);
    settle();

    send_idle_pct  = 26;
    recv_stall_pct = 26;
    write_limit(16'hFFFF);
    send_random_traffic(150);
    settle();

    if (board.mismatches == 0) begin
      $display("mstp_frame_receiver_unit regression: pass");
    end else begin
      $display("mstp_frame_receiver_unit regression: fail");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("mstp_frame_receiver_unit regression: fail");
    $finish;
  end

endmodule
